// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- sv/stmj_pkg.sv -----
// ----------------------------------------------------------------------------
// stmj_pkg
// Operation and status codes and the engine state encoding of the sorted
// table merge join.
// ----------------------------------------------------------------------------
package stmj_pkg;

    // Operation codes.
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_TRUNCATE = 2'd1;
    localparam logic [1:0] OP_ISECT    = 2'd2;
    localparam logic [1:0] OP_SYMDIFF  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Engine states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_WALK,
        S_EMIT,
        S_DONE
    } eng_state_t;

endpackage

// ----- sv/stmj_ram.sv -----
// ----------------------------------------------------------------------------
// stmj_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stmj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/stmj_front.sv -----
// ----------------------------------------------------------------------------
// stmj_front
// Command queue: accepts input transfers and holds them until the engine
// takes them, so that the input side and the engine stall independently.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module stmj_front
    import stmj_pkg::*;
#(
    parameter int W = 67
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output logic [W-1:0] cmd_data
);

    logic [W-1:0] q_reg [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_data;
        end
    end

    `ASSERT_CLK(a_cnt_range, clk, rst_n, cnt_reg != 2'd3, "queue count overflow")
    `ASSERT_CLK(a_ptr_cnt, clk, rst_n,
        (cnt_reg == 2'd1) == (wp_reg != rp_reg), "queue pointers disagree with count")
    `ASSERT_CLK(a_pop_nonempty, clk, rst_n, pop |-> cnt_reg != 2'd0, "pop from empty queue")

endmodule

// ----- sv/stmj_engine.sv -----
// ----------------------------------------------------------------------------
// stmj_engine
// Executes one command at a time on the two sorted tables held in RAMs:
// sorted insert with a search and a shift pass, truncate, and the merge walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module stmj_engine
    import stmj_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 32,
    parameter int DATA_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  logic [1:0]           cmd_op,
    input  logic                 cmd_sel,
    input  logic [KEY_BITS-1:0]  cmd_key,
    input  logic [DATA_BITS-1:0] cmd_payload,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [1:0]           res_status,
    output logic [KEY_BITS-1:0]  res_key,
    output logic [DATA_BITS-1:0] res_va,
    output logic [DATA_BITS-1:0] res_vb,
    output logic                 res_ha,
    output logic                 res_hb,
    output logic                 res_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RD = (TABLE_DEPTH > 1) ? TABLE_DEPTH : 2;
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    eng_state_t state_reg, state_next;

    logic [CW-1:0]        cnt_a_reg, cnt_b_reg;
    logic [1:0]           op_reg;
    logic                 sel_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_BITS-1:0] pay_reg;
    logic [1:0]           ins_st_reg;
    logic [CW-1:0]        i_reg, i_next, j_reg, j_next;
    logic                 any_reg;
    logic                 rd_ok_reg;

    // Row held back until it is known whether another row follows it.
    logic [KEY_BITS-1:0]  hkey_reg;
    logic [DATA_BITS-1:0] hva_reg, hvb_reg;
    logic                 hha_reg, hhb_reg;

    // Output register.
    logic                 ov_reg;
    logic [1:0]           ost_reg;
    logic [KEY_BITS-1:0]  okey_reg;
    logic [DATA_BITS-1:0] ova_reg, ovb_reg;
    logic                 oha_reg, ohb_reg, olast_reg;

    // RAM ports.
    logic                 we_a, we_b;
    logic [AW-1:0]        wa, ra_a, ra_b;
    logic [KEY_BITS-1:0]  wkey, ka, kb;
    logic [DATA_BITS-1:0] wval, va, vb;

    stmj_ram #(.WIDTH(KEY_BITS), .DEPTH(RD)) u_ka (.clk(clk), .we(we_a), .waddr(wa),
        .wdata(wkey), .raddr(ra_a), .rdata(ka));
    stmj_ram #(.WIDTH(DATA_BITS), .DEPTH(RD)) u_va (.clk(clk), .we(we_a), .waddr(wa),
        .wdata(wval), .raddr(ra_a), .rdata(va));
    stmj_ram #(.WIDTH(KEY_BITS), .DEPTH(RD)) u_kb (.clk(clk), .we(we_b), .waddr(wa),
        .wdata(wkey), .raddr(ra_b), .rdata(kb));
    stmj_ram #(.WIDTH(DATA_BITS), .DEPTH(RD)) u_vb (.clk(clk), .we(we_b), .waddr(wa),
        .wdata(wval), .raddr(ra_b), .rdata(vb));

    logic [CW-1:0]        n_sel;
    logic [KEY_BITS-1:0]  ks;
    logic [DATA_BITS-1:0] vs;
    logic                 out_free;
    logic                 a_live, b_live;
    logic                 emit;
    logic                 eq, alt;

    assign n_sel    = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign ks       = sel_reg ? kb : ka;
    assign vs       = sel_reg ? vb : va;
    assign out_free = !ov_reg || res_ready;
    assign a_live   = i_reg < cnt_a_reg;
    assign b_live   = j_reg < cnt_b_reg;
    assign eq       = ka == kb;
    assign alt      = ka < kb;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd_op)
                        OP_INSERT:   state_next = S_SEARCH;
                        OP_TRUNCATE: state_next = S_DONE;
                        default:     state_next = S_WALK;
                    endcase
                end
            end
            S_SEARCH:
            begin
                // i_reg is the probe index; the read of entry i-1 arrives now.
                if (rd_ok_reg && ks == key_reg)
                begin
                    state_next = S_DONE;
                end
                else if ((rd_ok_reg && ks > key_reg) || i_reg >= n_sel)
                begin
                    state_next = (n_sel >= FULL) ? S_DONE : S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (j_reg == i_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (rd_ok_reg)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (op_reg == OP_ISECT ? !(a_live && b_live) : !(a_live || b_live))
                begin
                    state_next = S_DONE;
                end
                else if (emit ? out_free : 1'b1)
                begin
                    state_next = S_WALK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Row emission decision in the walk.
    always_comb
    begin
        emit = 1'b0;
        if (op_reg == OP_ISECT)
        begin
            emit = a_live && b_live && eq;
        end
        else
        begin
            emit = (a_live && (!b_live || alt)) || (b_live && (!a_live || (!eq && !alt)));
        end
    end

    // Outputs to the RAMs and the command queue.
    always_comb
    begin
        cmd_ready = (state_reg == S_IDLE);
        we_a      = 1'b0;
        we_b      = 1'b0;
        wa        = '0;
        wkey      = ks;
        wval      = vs;
        ra_a      = i_reg[AW-1:0];
        ra_b      = j_reg[AW-1:0];
        i_next    = i_reg;
        j_next    = j_reg;
        case (state_reg)
            S_IDLE:
            begin
                i_next = '0;
                j_next = '0;
                ra_a   = '0;
                ra_b   = '0;
            end
            S_SEARCH:
            begin
                // Probe entry i; on stop, i-1 is the insert position if it was read and holds a larger key.
                ra_a = i_reg[AW-1:0];
                ra_b = i_reg[AW-1:0];
                if (state_next == S_SEARCH)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    // Insert position: entry that just arrived, or the end.
                    i_next = (rd_ok_reg && ks > key_reg) ? i_reg - 1'b1 : i_reg;
                    j_next = n_sel;
                    ra_a   = AW'(n_sel - 1'b1);
                    ra_b   = AW'(n_sel - 1'b1);
                end
            end
            S_SHIFT:
            begin
                // j is the slot written; the read of j-1 issued last cycle arrives now.
                wa = j_reg[AW-1:0];
                if (j_reg == i_reg)
                begin
                    wkey = key_reg;
                    wval = pay_reg;
                end
                we_a   = !sel_reg;
                we_b   = sel_reg;
                j_next = j_reg - 1'b1;
                ra_a   = AW'(j_reg - 2'd2);
                ra_b   = AW'(j_reg - 2'd2);
            end
            S_EMIT:
            begin
                if (state_next == S_WALK)
                begin
                    if (op_reg == OP_ISECT)
                    begin
                        i_next = (eq || alt) ? i_reg + 1'b1 : i_reg;
                        j_next = (eq || !alt) ? j_reg + 1'b1 : j_reg;
                    end
                    else
                    begin
                        if (a_live && (!b_live || alt))
                        begin
                            i_next = i_reg + 1'b1;
                        end
                        else if (b_live && (!a_live || !eq))
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = j_reg + 1'b1;
                        end
                    end
                    ra_a = i_next[AW-1:0];
                    ra_b = j_next[AW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Engine registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ov_reg    <= 1'b0;
            any_reg   <= 1'b0;
            rd_ok_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            rd_ok_reg <= (state_reg == S_SEARCH && state_next == S_SEARCH) ||
                         (state_reg == S_EMIT && state_next == S_WALK) ||
                         (state_reg == S_IDLE && state_next == S_WALK);
            if (res_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (state_reg == S_IDLE)
            begin
                any_reg <= 1'b0;
                if (cmd_valid && cmd_op == OP_TRUNCATE)
                begin
                    if (cmd_sel)
                    begin
                        cnt_b_reg <= '0;
                    end
                    else
                    begin
                        cnt_a_reg <= '0;
                    end
                end
            end
            if (state_reg == S_SHIFT && j_reg == i_reg)
            begin
                if (sel_reg)
                begin
                    cnt_b_reg <= cnt_b_reg + 1'b1;
                end
                else
                begin
                    cnt_a_reg <= cnt_a_reg + 1'b1;
                end
            end
            // A new row releases the held one, which is then not the last.
            if (state_reg == S_EMIT && emit && out_free)
            begin
                if (any_reg)
                begin
                    ov_reg <= 1'b1;
                end
                any_reg <= 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                ov_reg <= 1'b1;
            end
        end
    end

    // Command, held row and result payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            op_reg     <= cmd_op;
            sel_reg    <= cmd_sel;
            key_reg    <= cmd_key;
            pay_reg    <= cmd_payload;
            ins_st_reg <= ST_OK;
        end
        if (state_reg == S_SEARCH && state_next == S_DONE)
        begin
            ins_st_reg <= (rd_ok_reg && ks == key_reg) ? ST_DUP : ST_FULL;
        end
        if (state_reg == S_EMIT && emit && out_free)
        begin
            if (any_reg)
            begin
                ost_reg   <= ST_OK;
                olast_reg <= 1'b0;
                okey_reg  <= hkey_reg;
                ova_reg   <= hva_reg;
                ovb_reg   <= hvb_reg;
                oha_reg   <= hha_reg;
                ohb_reg   <= hhb_reg;
            end
            if (op_reg == OP_ISECT)
            begin
                hkey_reg <= ka;
                hva_reg  <= va;
                hvb_reg  <= vb;
                hha_reg  <= 1'b1;
                hhb_reg  <= 1'b1;
            end
            else if (a_live && (!b_live || alt))
            begin
                hkey_reg <= ka;
                hva_reg  <= va;
                hvb_reg  <= '0;
                hha_reg  <= 1'b1;
                hhb_reg  <= 1'b0;
            end
            else
            begin
                hkey_reg <= kb;
                hva_reg  <= '0;
                hvb_reg  <= vb;
                hha_reg  <= 1'b0;
                hhb_reg  <= 1'b1;
            end
        end
        if (state_reg == S_DONE && out_free)
        begin
            olast_reg <= 1'b1;
            if ((op_reg == OP_ISECT || op_reg == OP_SYMDIFF) && any_reg)
            begin
                // The held row closes the join.
                ost_reg  <= ST_OK;
                okey_reg <= hkey_reg;
                ova_reg  <= hva_reg;
                ovb_reg  <= hvb_reg;
                oha_reg  <= hha_reg;
                ohb_reg  <= hhb_reg;
            end
            else
            begin
                ova_reg  <= '0;
                ovb_reg  <= '0;
                oha_reg  <= 1'b0;
                ohb_reg  <= 1'b0;
                okey_reg <= (op_reg == OP_INSERT) ? key_reg : '0;
                if (op_reg == OP_INSERT)
                begin
                    ost_reg <= ins_st_reg;
                end
                else if (op_reg == OP_TRUNCATE)
                begin
                    ost_reg <= ST_OK;
                end
                else
                begin
                    ost_reg <= ST_EMPTY;
                end
            end
        end
    end

    assign res_valid  = ov_reg;
    assign res_status = ost_reg;
    assign res_key    = okey_reg;
    assign res_va     = ova_reg;
    assign res_vb     = ovb_reg;
    assign res_ha     = oha_reg;
    assign res_hb     = ohb_reg;
    assign res_last   = olast_reg;

    `ASSERT_CLK(a_cnt_a_max, clk, rst_n, cnt_a_reg <= FULL, "table A count above depth")
    `ASSERT_CLK(a_cnt_b_max, clk, rst_n, cnt_b_reg <= FULL, "table B count above depth")
    `ASSERT_CLK(a_hold_out, clk, rst_n, (ov_reg && !res_ready) |=> ov_reg,
        "result dropped while stalled")
    `ASSERT_CLK(a_shift_order, clk, rst_n, state_reg == S_SHIFT |-> j_reg >= i_reg,
        "shift pass ran below insert slot")

endmodule

// ----- sv/sorted_table_merge_join.sv -----
// Sorted table merge join. Two tables of up to TABLE_DEPTH key/payload pairs are
// kept in ascending key order in RAMs. Commands enter a two-entry queue and
// run one at a time. Insert locates the slot by a linear scan over the
// entries below the key and then shifts the tail up by one entry; truncate
// clears the table count; intersection and symmetric difference walk both
// tables, each step being one RAM read and then one compare. Each table RAM
// has a single read port.
// ----------------------------------------------------------------------------
// sorted_table_merge_join
// Top level: command queue in front, table engine with result register behind.
// ----------------------------------------------------------------------------
module sorted_table_merge_join
    import stmj_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 32,
    parameter int DATA_BITS   = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // tdata: op[1:0], key, payload (from bit 0 up), zero padded to bytes
    input  logic [((2 + KEY_BITS + DATA_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: table_sel
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // tdata: status[1:0], out_key, value_a, value_b (from bit 0 up), zero padded
    output logic [((2 + KEY_BITS + 2 * DATA_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // tuser: has_a, has_b (from bit 0 up)
    output logic [1:0] m_tuser,
    output logic m_tlast
);

    localparam int CW  = 3 + KEY_BITS + DATA_BITS;
    localparam int OW  = ((2 + KEY_BITS + 2 * DATA_BITS + 7) / 8) * 8;
    localparam int OPW = 2 + KEY_BITS + 2 * DATA_BITS;

    logic [CW-1:0]        qin, qout;
    logic                 cmd_valid, cmd_ready;
    logic [1:0]           st;
    logic [KEY_BITS-1:0]  rk;
    logic [DATA_BITS-1:0] ra, rb;

    assign qin = {s_tuser, s_tdata[CW-2:0]};

    stmj_front #(.W(CW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(qin),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(qout)
    );

    stmj_engine #(
        .TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)
    ) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd_op(qout[1:0]), .cmd_sel(qout[CW-1]),
        .cmd_key(qout[2 +: KEY_BITS]), .cmd_payload(qout[2 + KEY_BITS +: DATA_BITS]),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_status(st), .res_key(rk), .res_va(ra), .res_vb(rb),
        .res_ha(m_tuser[0]), .res_hb(m_tuser[1]), .res_last(m_tlast)
    );

    assign m_tdata = OW'({rb, ra, rk, st});

    // Result width sanity.
    if (OPW > OW)
    begin : g_bad
        $error("output packing too wide");
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted table merge join. A directed table of
// inserts, truncates and joins covers the key extremes, duplicates and empty
// joins; a full table follows. Random operations on small key spaces follow. Every
// result transfer is checked against a behavioral copy of both tables.
// ----------------------------------------------------------------------------
module testbench;
    import stmj_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 32;
    localparam int IN_W      = 72;
    localparam int OUT_W     = 104;
    localparam int IDLE_MAX  = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_key;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic        has_a;
        logic        has_b;
        logic        last;
    } join_row_t;

    typedef struct {
        logic [1:0]  op;
        logic        sel;
        logic [31:0] key;
        logic [31:0] payload;
        logic        typed;
        logic [1:0]  status;
    } cmd_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    // Model copy of the two tables.
    logic [31:0] tab_key [2][DEPTH];
    logic [31:0] tab_val [2][DEPTH];
    int          tab_cnt [2];

    join_row_t   pending_rows[$];
    logic [1:0]  typed_status[$];
    logic        typed_valid[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          quiet_tail = 0;
    bit          hold_off = 0;
    cmd_row_t    directed[$];

    sorted_table_merge_join dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Apply one command to the table copy and queue the rows it produces.
    task automatic predict_rows(input cmd_row_t c);
        join_row_t r;
        int i, j, n, pos, t;
        n = 0;
        t = c.sel;
        r = '0;
        if (c.op == OP_INSERT) begin
            pos = 0;
            while (pos < tab_cnt[t] && tab_key[t][pos] < c.key) pos++;
            r.out_key = c.key;
            r.last = 1'b1;
            if (pos < tab_cnt[t] && tab_key[t][pos] == c.key) r.status = ST_DUP;
            else if (tab_cnt[t] >= DEPTH) r.status = ST_FULL;
            else begin
                for (i = tab_cnt[t]; i > pos; i--) begin
                    tab_key[t][i] = tab_key[t][i-1];
                    tab_val[t][i] = tab_val[t][i-1];
                end
                tab_key[t][pos] = c.key;
                tab_val[t][pos] = c.payload;
                tab_cnt[t]++;
                r.status = ST_OK;
            end
            pending_rows.push_back(r);
            typed_status.push_back(c.status);
            typed_valid.push_back(c.typed);
            return;
        end
        if (c.op == OP_TRUNCATE) begin
            tab_cnt[t] = 0;
            r.status = ST_OK;
            r.last = 1'b1;
            pending_rows.push_back(r);
            typed_status.push_back(c.status);
            typed_valid.push_back(c.typed);
            return;
        end
        i = 0;
        j = 0;
        while (c.op == OP_ISECT ? (i < tab_cnt[0] && j < tab_cnt[1])
                                : (i < tab_cnt[0] || j < tab_cnt[1])) begin
            r = '0;
            if (i < tab_cnt[0] && j < tab_cnt[1] && tab_key[0][i] == tab_key[1][j]) begin
                if (c.op == OP_ISECT) begin
                    r.out_key = tab_key[0][i];
                    r.value_a = tab_val[0][i];
                    r.value_b = tab_val[1][j];
                    r.has_a = 1'b1;
                    r.has_b = 1'b1;
                    pending_rows.push_back(r);
                    n++;
                end
                i++;
                j++;
            end else if (j >= tab_cnt[1] || (i < tab_cnt[0] && tab_key[0][i] < tab_key[1][j]))
            begin
                if (c.op == OP_SYMDIFF) begin
                    r.out_key = tab_key[0][i];
                    r.value_a = tab_val[0][i];
                    r.has_a = 1'b1;
                    pending_rows.push_back(r);
                    n++;
                end
                i++;
            end else begin
                if (c.op == OP_SYMDIFF) begin
                    r.out_key = tab_key[1][j];
                    r.value_b = tab_val[1][j];
                    r.has_b = 1'b1;
                    pending_rows.push_back(r);
                    n++;
                end
                j++;
            end
        end
        if (n == 0) begin
            r = '0;
            r.status = ST_EMPTY;
            pending_rows.push_back(r);
            n = 1;
        end
        pending_rows[$].last = 1'b1;
        for (i = 0; i < n; i++) begin
            typed_status.push_back(c.status);
            typed_valid.push_back(c.typed && i == n - 1);
        end
    endtask

    // Offer one command and wait for its transfer.
    task automatic send_cmd(input cmd_row_t c);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b000000, c.payload, c.key, c.op};
        s_tuser <= c.sel;
        predict_rows(c);
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic cmd_row_t mk(input logic [1:0] op, input logic sel,
                                    input logic [31:0] key, input logic [31:0] pl,
                                    input logic typed, input logic [1:0] st);
        cmd_row_t c;
        c.op = op; c.sel = sel; c.key = key; c.payload = pl;
        c.typed = typed; c.status = st;
        return c;
    endfunction

    // Receiver: random stalls, one long hold-off, and the checker.
    always @(posedge clk) begin
        join_row_t got, want;
        if (m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[33:2], m_tdata[65:34], m_tdata[97:66],
                   m_tuser[0], m_tuser[1], m_tlast};
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected transfer, key", got.out_key, 32'h0);
            end else begin
                want = pending_rows.pop_front();
                if (typed_valid.pop_front() && typed_status[0] != got.status)
                    report_mismatch("typed status", got.status, typed_status[0]);
                void'(typed_status.pop_front());
                if (got.status != want.status) report_mismatch("status", got.status, want.status);
                if (got.out_key != want.out_key) report_mismatch("key", got.out_key, want.out_key);
                if (got.value_a != want.value_a)
                    report_mismatch("value_a", got.value_a, want.value_a);
                if (got.value_b != want.value_b)
                    report_mismatch("value_b", got.value_b, want.value_b);
                if (got.has_a != want.has_a) report_mismatch("has_a", got.has_a, want.has_a);
                if (got.has_b != want.has_b) report_mismatch("has_b", got.has_b, want.has_b);
                if (got.last != want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    initial begin : receiver
        int k;
        wait (rst_n);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                k = $urandom_range(1, 4);
                repeat (k) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("** sorted_table_merge_join: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        cmd_row_t c;
        int n, i, burst, space;
        tab_cnt[0] = 0;
        tab_cnt[1] = 0;
        // Directed: empty joins, extremes, duplicates, truncate.
        directed.push_back(mk(OP_ISECT, 0, 0, 0, 1, ST_EMPTY));
        directed.push_back(mk(OP_SYMDIFF, 1, 0, 0, 1, ST_EMPTY));
        directed.push_back(mk(OP_INSERT, 0, 32'h0, 32'hFFFF_FFFF, 1, ST_OK));
        directed.push_back(mk(OP_INSERT, 0, 32'hFFFF_FFFF, 32'h0, 1, ST_OK));
        directed.push_back(mk(OP_INSERT, 0, 32'hFFFF_FFFF, 32'h1234, 1, ST_DUP));
        directed.push_back(mk(OP_INSERT, 1, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 1, ST_OK));
        directed.push_back(mk(OP_INSERT, 1, 32'h8000_0000, 32'h5A5A_A5A5, 1, ST_OK));
        directed.push_back(mk(OP_ISECT, 0, 0, 0, 0, ST_OK));
        directed.push_back(mk(OP_SYMDIFF, 0, 0, 0, 0, ST_OK));
        directed.push_back(mk(OP_TRUNCATE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK));
        directed.push_back(mk(OP_ISECT, 1, 0, 0, 1, ST_EMPTY));
        directed.push_back(mk(OP_SYMDIFF, 0, 0, 0, 0, ST_OK));
        directed.push_back(mk(OP_TRUNCATE, 0, 0, 0, 1, ST_OK));
        directed.push_back(mk(OP_SYMDIFF, 0, 0, 0, 1, ST_EMPTY));

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_cmd(directed[i]);
        // Fill table B in descending order, then overflow and duplicate it.
        for (i = DEPTH; i > 0; i--)
            send_cmd(mk(OP_INSERT, 1, 32'(i * 3), $urandom, 1, ST_OK));
        send_cmd(mk(OP_INSERT, 1, 32'h7777, 32'h1, 1, ST_FULL));
        send_cmd(mk(OP_INSERT, 1, 3, 32'h1, 1, ST_DUP));
        // Long receiver hold-off while a full join is in flight.
        hold_off = 1;
        send_cmd(mk(OP_SYMDIFF, 0, 0, 0, 0, ST_OK));
        for (i = 0; i < 6; i++) send_cmd(mk(OP_INSERT, 0, 32'(i * 6), $urandom, 1, ST_OK));
        send_cmd(mk(OP_ISECT, 0, 0, 0, 0, ST_OK));

        // Random part: mostly inserts on small key spaces, joins now and then.
        n = 0;
        while (n < 105) begin
            space = ($urandom_range(0, 3) == 0) ? 255 : 40;
            burst = $urandom_range(3, 12);
            for (i = 0; i < burst; i++) begin
                c = mk(OP_INSERT, 1'($urandom_range(0, 1)), $urandom_range(0, space), $urandom,
                       0, ST_OK);
                if ($urandom_range(0, 7) == 0) c.key = $urandom;
                send_cmd(c);
                n++;
            end
            send_cmd(mk($urandom_range(0, 1) ? OP_ISECT : OP_SYMDIFF,
                        1'($urandom_range(0, 1)), $urandom, $urandom, 0, ST_OK));
            n++;
            if ($urandom_range(0, 5) == 0) begin
                send_cmd(mk(OP_TRUNCATE, 1'($urandom_range(0, 1)), $urandom, $urandom, 0,
                            ST_OK));
                n++;
            end
            if (n > 85) quiet_tail = 1;
        end
        s_tvalid <= 1'b0;

        wait (pending_rows.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0) $display("** sorted_table_merge_join: PASSED **");
        else $display("** sorted_table_merge_join: FAILED **");
        $finish;
    end
endmodule
